// File: sv/tfg_pkg.sv
// tfg_pkg: shared types and constants of the trilinear field gather block
// no dependencies
`default_nettype none

package tfg_pkg;

  // word kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_INV_X = 3'd0;
  localparam logic [2:0] CFG_INV_Y = 3'd1;
  localparam logic [2:0] CFG_INV_Z = 3'd2;
  localparam logic [2:0] CFG_GS_X  = 3'd3;
  localparam logic [2:0] CFG_GS_Y  = 3'd4;
  localparam logic [2:0] CFG_GS_Z  = 3'd5;
  localparam logic [2:0] CFG_QM    = 3'd6;

  // reset values
  localparam logic [31:0] INV_RESET = 32'd65536;
  localparam logic [4:0]  GS_RESET  = 5'd16;
  localparam logic [31:0] QM_RESET  = 32'd65536;

  // fixed point constants
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [48:0] W_ROUND   = 49'h0_0000_8000_0000;
  localparam logic signed [36:0] CLAMP_HI = 37'sd4294967295;
  localparam logic signed [36:0] CLAMP_LO = -37'sd4294967295;
  localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
  localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

  // per axis decode of a query position
  typedef struct packed {
    logic [15:0] frac;
    logic        in_lo;
    logic        in_hi;
    logic        par;
  } axis_t;

endpackage

`default_nettype wire

// File: sv/tfg_ram.sv
// tfg_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`default_nettype none

module tfg_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/tfg_axis.sv
// tfg_axis: one axis of the position decode, scale then cell, fraction and bounds
// depends on tfg_pkg
`default_nettype none

module tfg_axis #(
  parameter int MAX_GRID = 16,
  parameter int HALF     = (MAX_GRID + 1) / 2,
  parameter int HW       = (HALF > 1) ? $clog2(HALF) : 1
) (
  input  wire logic               clk,
  input  wire logic               en1,
  input  wire logic               en2,
  input  wire logic signed [31:0] pos,
  input  wire logic        [31:0] inv,
  input  wire logic        [4:0]  gs,
  output tfg_pkg::axis_t          ax_r,
  output logic             [HW-1:0] half_r
);
  import tfg_pkg::*;

  localparam int LW = ($clog2(MAX_GRID + 1) > 5) ? $clog2(MAX_GRID + 1) : 5;

  logic signed [32:0] inv_s;
  logic signed [63:0] p_nxt, p_r;
  logic [31:0]        cidx;
  logic [32:0]        cell_hi;
  logic [LW-1:0]      lim;
  axis_t              ax_nxt;

  // stage 1: exact q32.32 product
  assign inv_s = $signed({1'b0, inv});
  assign p_nxt = pos * inv_s;

  always_ff @(posedge clk) begin
    if (en1) begin
      p_r <= p_nxt;
    end
  end

  // stage 2: floor to cell, keep fraction, test both corners against the grid
  assign cidx    = p_r[63:32];
  assign cell_hi = {cidx[31], cidx} + 33'd1;
  assign lim     = (LW'(gs) < LW'(MAX_GRID)) ? LW'(gs) : LW'(MAX_GRID);

  always_comb begin
    ax_nxt.frac  = p_r[31:16];
    ax_nxt.in_lo = !cidx[31] && (cidx < 32'(lim));
    ax_nxt.in_hi = !cell_hi[32] && (cell_hi < 33'(lim));
    ax_nxt.par   = cidx[0];
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ax_r   <= ax_nxt;
      half_r <= cidx[HW:1];
    end
  end

endmodule

`default_nettype wire

// File: sv/tfg_back.sv
// tfg_back: per component weighted sum, clamp, charge over mass scale, saturate
// depends on tfg_pkg
`default_nettype none

module tfg_back (
  input  wire logic               clk,
  input  wire logic [4:0]         en,
  input  wire logic        [16:0] w [8],
  input  wire logic signed [31:0] fld [8],
  input  wire logic signed [31:0] qm,
  output logic signed [31:0]      force_r
);
  import tfg_pkg::*;

  logic signed [49:0] prod_r [8];
  logic signed [51:0] sum_r [2];
  logic signed [52:0] acc;
  logic signed [36:0] sh;
  logic signed [32:0] s_nxt, s_r;
  logic signed [64:0] m_r;
  logic signed [48:0] t;
  logic signed [31:0] force_nxt;

  // stage 5: weight times field per corner
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 8; k++) begin
        prod_r[k] <= $signed({1'b0, w[k]}) * fld[k];
      end
    end
  end

  // stage 6: two sums of four
  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum_r[0] <= prod_r[0] + prod_r[1] + prod_r[2] + prod_r[3];
      sum_r[1] <= prod_r[4] + prod_r[5] + prod_r[6] + prod_r[7];
    end
  end

  // stage 7: final sum, floor to q16.16, clamp
  assign acc = sum_r[0] + sum_r[1];
  assign sh  = acc[52:16];

  always_comb begin
    if (sh > CLAMP_HI) begin
      s_nxt = CLAMP_HI[32:0];
    end else if (sh < CLAMP_LO) begin
      s_nxt = CLAMP_LO[32:0];
    end else begin
      s_nxt = sh[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s_r <= s_nxt;
    end
  end

  // stage 8: scale by charge over mass
  always_ff @(posedge clk) begin
    if (en[3]) begin
      m_r <= s_r * qm;
    end
  end

  // stage 9: floor and saturate into the output word
  assign t = m_r[64:16];

  always_comb begin
    if (t > SAT_HI) begin
      force_nxt = SAT_HI[31:0];
    end else if (t < SAT_LO) begin
      force_nxt = SAT_LO[31:0];
    end else begin
      force_nxt = t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      force_r <= force_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/trilinear_field_gather_top.sv
// trilinear_field_gather_top: field store banks, pipeline control, corner weights
// depends on tfg_pkg, tfg_ram, tfg_axis, tfg_back
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   kind, component, cell, field value, position
//  out      output     out_valid / out_ready three forces, no_corner_inside
//  cfg      input      cfg_we                cfg_index, cfg_data
//
// nine register stages; a word enters every cycle while the output is not stalled,
// and a query result leaves from the last stage. the rate is set by the eight parity
// banks of the field store, which give all corners of a cell in one read.
// each stage holds only while the stage after it is full and stalled, so
// bubbles (loads drop out after their write) are squeezed out. no clearing pass.
`default_nettype none

module trilinear_field_gather_top #(
  parameter int MAX_GRID_X = 16,
  parameter int MAX_GRID_Y = 16,
  parameter int MAX_GRID_Z = 16,
  parameter int NUM_AXES   = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic        [1:0]  in_component,
  input  wire logic        [3:0]  in_cell_x,
  input  wire logic        [3:0]  in_cell_y,
  input  wire logic        [3:0]  in_cell_z,
  input  wire logic signed [31:0] in_field_value,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_force_x,
  output logic signed [31:0]      out_force_y,
  output logic signed [31:0]      out_force_z,
  output logic                    out_no_corner_inside,
  input  wire logic               cfg_we,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [31:0] cfg_data
);
  import tfg_pkg::*;

  localparam int HX  = (MAX_GRID_X + 1) / 2;
  localparam int HY  = (MAX_GRID_Y + 1) / 2;
  localparam int HZ  = (MAX_GRID_Z + 1) / 2;
  localparam int HXW = (HX > 1) ? $clog2(HX) : 1;
  localparam int HYW = (HY > 1) ? $clog2(HY) : 1;
  localparam int HZW = (HZ > 1) ? $clog2(HZ) : 1;
  localparam int BD  = HX * HY * HZ;
  localparam int AW  = (BD > 1) ? $clog2(BD) : 1;
  localparam int CW  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  // configuration registers
  logic [31:0]        inv_r [3];
  logic [4:0]         gs_r [3];
  logic signed [31:0] qm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r[0] <= INV_RESET;
      inv_r[1] <= INV_RESET;
      inv_r[2] <= INV_RESET;
      gs_r[0]  <= GS_RESET;
      gs_r[1]  <= GS_RESET;
      gs_r[2]  <= GS_RESET;
      qm_r     <= QM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INV_X: inv_r[0] <= cfg_data;
        CFG_INV_Y: inv_r[1] <= cfg_data;
        CFG_INV_Z: inv_r[2] <= cfg_data;
        CFG_GS_X:  gs_r[0]  <= cfg_data[4:0];
        CFG_GS_Y:  gs_r[1]  <= cfg_data[4:0];
        CFG_GS_Z:  gs_r[2]  <= cfg_data[4:0];
        CFG_QM:    qm_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valid bits and enables; a stage loads when empty or when it moves on
  logic [9:1] v_r;
  logic [9:1] en;
  logic       q1_r, q2_r;

  always_comb begin
    en[9] = !v_r[9] || out_ready;
    for (int k = 8; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2] && (q2_r == KIND_QUERY);
      for (int k = 4; k <= 9; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // load word carried to the write point
  logic [1:0]         comp1_r, comp2_r;
  logic [3:0]         lx1_r, ly1_r, lz1_r, lx2_r, ly2_r, lz2_r;
  logic signed [31:0] val1_r, val2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q1_r    <= in_kind;
      comp1_r <= in_component;
      lx1_r   <= in_cell_x;
      ly1_r   <= in_cell_y;
      lz1_r   <= in_cell_z;
      val1_r  <= in_field_value;
    end
    if (en[2]) begin
      q2_r    <= q1_r;
      comp2_r <= comp1_r;
      lx2_r   <= lx1_r;
      ly2_r   <= ly1_r;
      lz2_r   <= lz1_r;
      val2_r  <= val1_r;
    end
  end

  // position decode, stages 1 and 2
  axis_t          ax [3];
  logic [HXW-1:0] hx;
  logic [HYW-1:0] hy;
  logic [HZW-1:0] hz;

  tfg_axis #(.MAX_GRID(MAX_GRID_X)) u_ax_x (
    .clk(clk), .en1(en[1]), .en2(en[2]), .pos(in_pos_x), .inv(inv_r[0]),
    .gs(gs_r[0]), .ax_r(ax[0]), .half_r(hx)
  );
  tfg_axis #(.MAX_GRID(MAX_GRID_Y)) u_ax_y (
    .clk(clk), .en1(en[1]), .en2(en[2]), .pos(in_pos_y), .inv(inv_r[1]),
    .gs(gs_r[1]), .ax_r(ax[1]), .half_r(hy)
  );
  tfg_axis #(.MAX_GRID(MAX_GRID_Z)) u_ax_z (
    .clk(clk), .en1(en[1]), .en2(en[2]), .pos(in_pos_z), .inv(inv_r[2]),
    .gs(gs_r[2]), .ax_r(ax[2]), .half_r(hz)
  );

  // load write decode
  logic          ld_ok;
  logic [2:0]    wbank;
  logic [AW-1:0] waddr;

  assign ld_ok = v_r[2] && (q2_r == KIND_LOAD) && en[3] &&
                 (32'(comp2_r) < 32'(NUM_AXES)) && (32'(lx2_r) < 32'(MAX_GRID_X)) &&
                 (32'(ly2_r) < 32'(MAX_GRID_Y)) && (32'(lz2_r) < 32'(MAX_GRID_Z));
  assign wbank = {lx2_r[0], ly2_r[0], lz2_r[0]};
  assign waddr = AW'((32'(lx2_r[3:1]) * HY + 32'(ly2_r[3:1])) * HZ + 32'(lz2_r[3:1]));

  // field banks: one per corner parity and component
  logic signed [31:0] rdq [8][NUM_AXES];
  logic [16:0]        fab_w [8];
  logic [16:0]        fb_w [8];
  logic [16:0]        fc_w [8];
  logic               cin_w [8];
  logic [33:0]        fab3_r [8];
  logic [16:0]        fc3_r [8];
  logic               cin3_r [8];
  logic               none3_r, none4_r, none5_r, none6_r, none7_r, none8_r, none9_r;

  for (genvar k = 0; k < 8; k++) begin : g_bank
    localparam logic BX = 1'((k >> 2) & 1);
    localparam logic BY = 1'((k >> 1) & 1);
    localparam logic BZ = 1'(k & 1);
    logic          lx, ly, lz;
    logic [HXW-1:0] bhx;
    logic [HYW-1:0] bhy;
    logic [HZW-1:0] bhz;
    logic [AW-1:0]  raddr;
    logic [16:0]    fa;

    // corner of this bank is the high one when parity differs
    assign lx  = ax[0].par ^ BX;
    assign ly  = ax[1].par ^ BY;
    assign lz  = ax[2].par ^ BZ;
    assign bhx = hx + HXW'(ax[0].par & ~BX);
    assign bhy = hy + HYW'(ax[1].par & ~BY);
    assign bhz = hz + HZW'(ax[2].par & ~BZ);
    assign raddr = AW'((32'(bhx) * HY + 32'(bhy)) * HZ + 32'(bhz));

    assign fa       = lx ? {1'b0, ax[0].frac} : ONE_Q16 - {1'b0, ax[0].frac};
    assign fb_w[k]  = ly ? {1'b0, ax[1].frac} : ONE_Q16 - {1'b0, ax[1].frac};
    assign fc_w[k]  = lz ? {1'b0, ax[2].frac} : ONE_Q16 - {1'b0, ax[2].frac};
    assign fab_w[k] = fa;
    assign cin_w[k] = (lx ? ax[0].in_hi : ax[0].in_lo) &&
                      (ly ? ax[1].in_hi : ax[1].in_lo) &&
                      (lz ? ax[2].in_hi : ax[2].in_lo);

    for (genvar c = 0; c < NUM_AXES; c++) begin : g_comp
      logic [31:0] q;
      tfg_ram #(.W(32), .DEPTH(BD)) u_ram (
        .clk(clk),
        .we(ld_ok && (wbank == 3'(k)) && (comp2_r == CW'(c))),
        .waddr(waddr), .wdata(val2_r),
        .re(en[3]), .raddr(raddr), .rdata(q)
      );
      assign rdq[k][c] = $signed(q);
    end
  end

  // stage 3: first weight product
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 8; k++) begin
        fab3_r[k] <= fab_w[k] * fb_w[k];
        fc3_r[k]  <= fc_w[k];
        cin3_r[k] <= cin_w[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      none3_r <= !((ax[0].in_lo || ax[0].in_hi) && (ax[1].in_lo || ax[1].in_hi) &&
                   (ax[2].in_lo || ax[2].in_hi));
    end
  end

  // stage 4: rounded corner weights, fields of outside corners forced to zero
  logic [16:0]        w4_r [8];
  logic signed [31:0] fld4_r [3][8];
  logic [48:0]        wt [8];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      wt[k] = fab3_r[k] * fc3_r[k] + W_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 8; k++) begin
        w4_r[k] <= wt[k][48:32];
        for (int c = 0; c < 3; c++) begin
          fld4_r[c][k] <= cin3_r[k] ? rdq[k][c] : 32'sd0;
        end
      end
      none4_r <= none3_r;
    end
  end

  // flag travels alongside the back end stages
  always_ff @(posedge clk) begin
    if (en[5]) none5_r <= none4_r;
    if (en[6]) none6_r <= none5_r;
    if (en[7]) none7_r <= none6_r;
    if (en[8]) none8_r <= none7_r;
    if (en[9]) none9_r <= none8_r;
  end

  // stages 5 to 9, one unit per component
  tfg_back u_back_x (
    .clk(clk), .en(en[9:5]), .w(w4_r), .fld(fld4_r[0]), .qm(qm_r), .force_r(out_force_x)
  );
  tfg_back u_back_y (
    .clk(clk), .en(en[9:5]), .w(w4_r), .fld(fld4_r[1]), .qm(qm_r), .force_r(out_force_y)
  );
  tfg_back u_back_z (
    .clk(clk), .en(en[9:5]), .w(w4_r), .fld(fld4_r[2]), .qm(qm_r), .force_r(out_force_z)
  );

  assign out_valid            = v_r[9];
  assign out_no_corner_inside = none9_r;

  // input is refused only behind a stalled, full output stage
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_r[9] && !out_ready))
    else $error("input stalled without a stalled output");

  // a load never reaches the weight stages
  a_load_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[2] && (q2_r == KIND_LOAD) && en[3]) |=> !v_r[3])
    else $error("load word passed the write stage");

  // no inside corner gives zero forces
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_corner_inside) |->
      (out_force_x == 32'sd0 && out_force_y == 32'sd0 && out_force_z == 32'sd0))
    else $error("nonzero force with no corner inside");

endmodule

`default_nettype wire

// File: tb/sv/trilinear_field_gather_top_tb.sv
// trilinear_field_gather_top_tb: self-checking bench for the field gather block
// drives load and query words, predicts each force result, checks the result stream
// depends on tfg_pkg and trilinear_field_gather_top
`default_nettype none

module trilinear_field_gather_top_tb;
  import tfg_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int NAX = 3;
  localparam int GMAX = 16;
  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE = 12;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic               nci;
  } force_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [1:0] in_component = '0;
  logic [3:0] in_cell_x = '0, in_cell_y = '0, in_cell_z = '0;
  logic signed [31:0] in_field_value = '0, in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_force_x, out_force_y, out_force_z;
  logic out_no_corner_inside;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor state
  int  field_mem [NAX][GMAX][GMAX][GMAX];
  bit  field_set [NAX][GMAX][GMAX][GMAX];
  logic [31:0] inv_sp [NAX];
  logic [4:0]  gsize [NAX];
  logic signed [31:0] q_over_m;

  force_t force_q[$];
  int idle_pct = 0, stall_pct = 0, hold_left = 0;
  int errors = 0, n_words = 0, n_queries = 0, n_checked = 0, n_empty = 0;
  int quiet_cycles = 0;

  trilinear_field_gather_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    force_t want;
    if (out_valid && out_ready) begin
      if (force_q.size() == 0) begin
        $display("%0t: unexpected result word fx=%h fy=%h fz=%h nci=%b", $time,
                 out_force_x, out_force_y, out_force_z, out_no_corner_inside);
        errors++;
      end else begin
        want = force_q.pop_front();
        n_checked++;
        if (out_no_corner_inside) n_empty++;
        if (out_force_x !== want.fx) begin
          $display("%0t: force_x exp %h act %h", $time, want.fx, out_force_x);
          errors++;
        end
        if (out_force_y !== want.fy) begin
          $display("%0t: force_y exp %h act %h", $time, want.fy, out_force_y);
          errors++;
        end
        if (out_force_z !== want.fz) begin
          $display("%0t: force_z exp %h act %h", $time, want.fz, out_force_z);
          errors++;
        end
        if (out_no_corner_inside !== want.nci) begin
          $display("%0t: no_corner_inside exp %b act %b", $time, want.nci,
                   out_no_corner_inside);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("timeout with %0d results outstanding", force_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int active_lim(int a);
    return (gsize[a] > GMAX) ? GMAX : int'(gsize[a]);
  endfunction

  // scaled position, exact Q32.32
  function automatic longint scaled_pos(int a, logic signed [31:0] pos);
    longint p64, s64;
    p64 = pos;
    s64 = {32'b0, inv_sp[a]};
    return p64 * s64;
  endfunction

  // cloud-in-cell gather of the stored field at one position
  function automatic force_t gather_force(logic signed [31:0] px, logic signed [31:0] py,
                                          logic signed [31:0] pz);
    longint cidx [NAX];
    longint frac [NAX];
    longint acc [NAX];
    longint p, fa, fb, fc, w, s, cx, cy, cz;
    logic signed [95:0] r;
    bit hit_any;
    force_t res;
    hit_any = 0;
    for (int a = 0; a < NAX; a++) begin
      p = scaled_pos(a, (a == 0) ? px : (a == 1) ? py : pz);
      cidx[a] = p >>> 32;
      frac[a] = (p >> 16) & 64'hFFFF;
      acc[a] = 0;
    end
    for (int l = 0; l < 2; l++)
      for (int m = 0; m < 2; m++)
        for (int n = 0; n < 2; n++) begin
          cx = cidx[0] + l;
          cy = cidx[1] + m;
          cz = cidx[2] + n;
          if (cx < 0 || cy < 0 || cz < 0 || cx >= active_lim(0) || cy >= active_lim(1) ||
              cz >= active_lim(2))
            continue;
          hit_any = 1;
          fa = l ? frac[0] : 65536 - frac[0];
          fb = m ? frac[1] : 65536 - frac[1];
          fc = n ? frac[2] : 65536 - frac[2];
          w = (fa * fb * fc + 64'h8000_0000) >> 32;
          for (int c = 0; c < NAX; c++)
            acc[c] += w * longint'(field_mem[c][cx][cy][cz]);
        end
    for (int c = 0; c < NAX; c++) begin
      s = acc[c] >>> 16;
      if (s > 64'sd4294967295) s = 64'sd4294967295;
      if (s < -64'sd4294967295) s = -64'sd4294967295;
      r = 96'(s) * 96'(q_over_m);
      r = r >>> 16;
      if (r > 96'sd2147483647) r = 96'sd2147483647;
      if (r < -96'sd2147483648) r = -96'sd2147483648;
      if (c == 0) res.fx = r[31:0];
      else if (c == 1) res.fy = r[31:0];
      else res.fz = r[31:0];
    end
    res.nci = !hit_any;
    return res;
  endfunction

  // send one word, with random sender gaps, and update the predictor on acceptance
  task automatic send_word(logic kind, logic [1:0] comp, logic [3:0] x, logic [3:0] y,
                           logic [3:0] z, logic signed [31:0] fv, logic signed [31:0] px,
                           logic signed [31:0] py, logic signed [31:0] pz);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_component <= comp;
    in_cell_x <= x;
    in_cell_y <= y;
    in_cell_z <= z;
    in_field_value <= fv;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    do @(posedge clk); while (!in_ready);
    n_words++;
    if (kind == KIND_LOAD) begin
      if (comp < NAX) begin
        field_mem[comp][x][y][z] = fv;
        field_set[comp][x][y][z] = 1'b1;
      end
    end else begin
      force_q.push_back(gather_force(px, py, pz));
      n_queries++;
    end
  endtask

  task automatic load_word(logic [1:0] comp, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                           logic signed [31:0] fv);
    send_word(KIND_LOAD, comp, x, y, z, fv, $urandom, $urandom, $urandom);
  endtask

  function automatic logic signed [31:0] rand_field();
    if ($urandom_range(0, 1)) return $urandom;
    return int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
  endfunction

  // query, after filling any corner it will read that was never written
  task automatic query_at(logic signed [31:0] px, logic signed [31:0] py,
                          logic signed [31:0] pz);
    longint cidx [NAX];
    longint cx, cy, cz;
    cidx[0] = scaled_pos(0, px) >>> 32;
    cidx[1] = scaled_pos(1, py) >>> 32;
    cidx[2] = scaled_pos(2, pz) >>> 32;
    for (int l = 0; l < 2; l++)
      for (int m = 0; m < 2; m++)
        for (int n = 0; n < 2; n++) begin
          cx = cidx[0] + l;
          cy = cidx[1] + m;
          cz = cidx[2] + n;
          if (cx < 0 || cy < 0 || cz < 0 || cx >= active_lim(0) || cy >= active_lim(1) ||
              cz >= active_lim(2))
            continue;
          for (int c = 0; c < NAX; c++)
            if (!field_set[c][cx][cy][cz])
              load_word(2'(c), 4'(cx), 4'(cy), 4'(cz), rand_field());
        end
    send_word(KIND_QUERY, 2'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
              $urandom, px, py, pz);
  endtask

  // position near the low or high edge of the active grid, or fully random now and then
  function automatic logic signed [31:0] aim_pos(int a);
    longint t, s64, p;
    int ci;
    if ($urandom_range(0, 4) == 0 || inv_sp[a] == 0) return $urandom;
    // two small windows keep the set of touched corners small
    if ($urandom_range(0, 1)) ci = int'($urandom_range(0, 2)) - 1;
    else ci = active_lim(a) - int'($urandom_range(0, 2));
    t = (longint'(ci) <<< 32) | longint'({32'b0, $urandom});
    s64 = {32'b0, inv_sp[a]};
    p = t / s64;
    if (p > 64'sd2147483647 || p < -64'sd2147483648) return $urandom;
    return p[31:0];
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    wait (force_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INV_X: inv_sp[0] = data;
      CFG_INV_Y: inv_sp[1] = data;
      CFG_INV_Z: inv_sp[2] = data;
      CFG_GS_X:  gsize[0] = data[4:0];
      CFG_GS_Y:  gsize[1] = data[4:0];
      CFG_GS_Z:  gsize[2] = data[4:0];
      CFG_QM:    q_over_m = data;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz, logic [4:0] gx,
                         logic [4:0] gy, logic [4:0] gz, logic [31:0] qm);
    drain();
    set_reg(CFG_INV_X, ix);
    set_reg(CFG_INV_Y, iy);
    set_reg(CFG_INV_Z, iz);
    set_reg(CFG_GS_X, {27'b0, gx});
    set_reg(CFG_GS_Y, {27'b0, gy});
    set_reg(CFG_GS_Z, {27'b0, gz});
    set_reg(CFG_QM, qm);
  endtask

  // mix of aimed queries, random loads and ignored loads
  task automatic run_mix(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) query_at(aim_pos(0), aim_pos(1), aim_pos(2));
      else if (r < 90) load_word(2'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
                                 4'($urandom), rand_field());
      else load_word(2'd3, 4'($urandom), 4'($urandom), 4'($urandom), $urandom);
    end
  endtask

  // extremes of fields, ignored load, corner and out-of-grid queries
  task automatic test_directed();
    load_word(2'd0, 4'd0, 4'd0, 4'd0, 32'sh7FFF_FFFF);
    load_word(2'd1, 4'd0, 4'd0, 4'd0, 32'sh8000_0000);
    load_word(2'd2, 4'd0, 4'd0, 4'd0, 32'sd65536);
    load_word(2'd0, 4'd15, 4'd15, 4'd15, -32'sd1);
    load_word(2'd3, 4'hF, 4'hA, 4'h5, 32'h5A5A_A5A5);
    query_at(0, 0, 0);
    query_at(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
    query_at(-32'sh0000_8000, -32'sh0000_4000, 32'sh0000_C000);
    query_at(15 <<< 16, 15 <<< 16, 15 <<< 16);
    query_at((15 <<< 16) + 32'h8000, 32'h0007_FFFF, 32'h000E_0001);
    query_at(32'sh7FFF_FFFF, 0, 0);
    query_at(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    query_at(-32'sd1, -32'sd1, -32'sd1);
    query_at(16 <<< 16, 3 <<< 16, 3 <<< 16);
    query_at(-(2 <<< 16), 0, 0);
    query_at(32'h000A_FFFF, 32'h0005_0001, 32'h000C_8000);
  endtask

  // random traffic under each idling pattern
  task automatic test_idling();
    idle_pct = 0;  stall_pct = 0;  run_mix(180);
    idle_pct = 64; stall_pct = 0;  run_mix(140);
    idle_pct = 0;  stall_pct = 64; run_mix(140);
    idle_pct = 25; stall_pct = 25; run_mix(140);
    idle_pct = 0;  stall_pct = 0;
  endtask

  // long receiver hold-off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    drain();
    hold_left = 300;
    for (int i = 0; i < 60; i++) query_at(aim_pos(0), aim_pos(1), aim_pos(2));
    drain();
  endtask

  // several register settings, extremes included
  task automatic test_config_sweep();
    set_all(32'h0000_8000, 32'h0002_0000, 32'h0001_8000, 5'd7, 5'd3, 5'd12, 32'hFFFE_8000);
    idle_pct = 25; stall_pct = 25; run_mix(90);
    set_all(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 5'd1, 5'd16, 5'd2, 32'h8000_0000);
    run_mix(60);
    set_all(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 5'd0, 5'd31, 5'd16, 32'h7FFF_FFFF);
    run_mix(40);
    set_all(32'h0003_0000, 32'h0000_4000, 32'h0001_0000, 5'd31, 5'd2, 5'd9, 32'h0000_0000);
    run_mix(60);
    set_all(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 5'd16, 5'd16, 5'd16,
            32'h7FFF_FFFF);
    run_mix(70);
    drain();
    set_reg(CFG_UNUSED, 32'hDEAD_BEEF);
    run_mix(30);
  endtask

  initial begin
    for (int a = 0; a < NAX; a++) begin
      inv_sp[a] = INV_RESET;
      gsize[a] = GS_RESET;
    end
    q_over_m = QM_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_idling();
    test_backpressure();
    test_config_sweep();
    drain();
    $display("covered %0d words, %0d queries, %0d results checked (%0d outside grid)",
             n_words, n_queries, n_checked, n_empty);
    $display("register sweep, idle and stall patterns, long hold-off; %0d mismatches",
             errors);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
